### rtl/mpfsa_pkg.sv
// Shared types, constants and helper functions of the multi-pool free-stack allocator.
`timescale 1ns / 1ps
`default_nettype none
package mpfsa_pkg;

	localparam int NUM_POOLS   = 4;
	localparam int POOL_W      = 2;
	localparam int SLOT_W      = 8;
	localparam int SLOT_CAP    = 256;
	localparam int CNT_W       = 9;
	localparam int LIMIT_W     = 9;
	localparam int BYTES_W     = 13;
	localparam int BYTES_MAX   = 4096;
	localparam int OFFS_W      = 20;
	localparam int STATUS_W    = 2;
	localparam int STACK_W     = POOL_W + SLOT_W;
	localparam int STACK_DEPTH = NUM_POOLS * SLOT_CAP;
	localparam int MUL_CNT_W   = $clog2(SLOT_W);

	localparam int CFG_ADDR_W     = 4;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_LIMIT_BASE = 0;
	localparam int CFG_BYTES_BASE = 4;
	localparam int CFG_NUM_REGS   = 8;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_FETCH,
		FSM_MUL,
		FSM_OUT
	} fsm_t;

	// Clamp a limit register to 1..SLOT_CAP
	function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (CNT_W'(v) > CNT_W'(SLOT_CAP))
			r = CNT_W'(SLOT_CAP);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	// Clamp a slot size register to 1..BYTES_MAX
	function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] v);
		logic [BYTES_W-1:0] r;
		if (v == '0)
			r = BYTES_W'(1);
		else if (v > BYTES_W'(BYTES_MAX))
			r = BYTES_W'(BYTES_MAX);
		else
			r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/mpfsa_ifs.sv
// Request, response and configuration channel interfaces of the allocator.
`timescale 1ns / 1ps
`default_nettype none
interface mpfsa_req_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [mpfsa_pkg::POOL_W-1:0]     pool_id;
	logic [mpfsa_pkg::SLOT_W-1:0]     slot_in;
	modport source (output valid, output kind, output pool_id, output slot_in, input ready);
	modport sink   (input valid, input kind, input pool_id, input slot_in, output ready);
endinterface

interface mpfsa_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [mpfsa_pkg::STATUS_W-1:0]   status;
	logic [mpfsa_pkg::SLOT_W-1:0]     slot_out;
	logic [mpfsa_pkg::OFFS_W-1:0]     byte_offset;
	logic [mpfsa_pkg::CNT_W-1:0]      free_left;
	modport source (output valid, output status, output slot_out, output byte_offset,
		output free_left, input ready);
	modport sink   (input valid, input status, input slot_out, input byte_offset,
		input free_left, output ready);
endinterface

interface mpfsa_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mpfsa_pkg::CFG_ADDR_W-1:0] addr;
	logic [mpfsa_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

### rtl/mpfsa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mpfsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/multi_pool_free_stack_allocator.sv
// Top level: four-pool free-stack slot allocator with shift-add offset unit.
// Sequence: after the request transfer the FETCH state does the stack read, then the shared
// shift-add multiplier forms slot times slot size in the MUL state before the result is offered.
// Request flow: a new request is taken only after the previous response has transferred; the 8-step
// multiplier and the registered stack read set the request rate.
// Reset: limits 256 and slot sizes 1; each pool's count and low-water mark are set to its
// limit at once, so no stack clearing pass is needed and requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
module multi_pool_free_stack_allocator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mpfsa_req_if.sink   req,
	mpfsa_rsp_if.source rsp,
	mpfsa_cfg_if.sink   cfg
);

	localparam int NP = mpfsa_pkg::NUM_POOLS;

	// Configuration and per-pool stack bookkeeping
	logic [mpfsa_pkg::LIMIT_W-1:0] limit_q [NP];
	logic [mpfsa_pkg::BYTES_W-1:0] bytes_q [NP];
	logic [mpfsa_pkg::CNT_W-1:0]   cnt_q   [NP];
	logic [mpfsa_pkg::CNT_W-1:0]   low_q   [NP];
	logic [mpfsa_pkg::LIMIT_W-1:0] limit_d [NP];

	// Sequencer and item registers
	mpfsa_pkg::fsm_t    state_q, state_d;
	logic               kind_q;
	mpfsa_pkg::status_t status_q;
	logic [mpfsa_pkg::SLOT_W-1:0]    slot_q;
	logic [mpfsa_pkg::CNT_W-1:0]     left_q;
	logic                            sel_ram_q;
	logic [mpfsa_pkg::OFFS_W-1:0]    acc_q;
	logic [mpfsa_pkg::OFFS_W-1:0]    mcand_q;
	logic [mpfsa_pkg::SLOT_W-1:0]    mplier_q;
	logic [mpfsa_pkg::MUL_CNT_W-1:0] step_q;

	// Request decode
	logic                          req_fire, cfg_fire, cfg_hit;
	logic                          pool_ok, alloc_ok, free_ok, use_ram;
	logic [mpfsa_pkg::CNT_W-1:0]   cur_cnt, cur_low, cur_lim, cnt_dec, cnt_inc, dflt_slot;
	logic [mpfsa_pkg::BYTES_W-1:0] cur_bytes;
	logic [mpfsa_pkg::SLOT_W-1:0]  ram_rdata, slot_res;
	logic                          ram_we;
	logic [mpfsa_pkg::STACK_W-1:0] ram_waddr, ram_raddr;
	logic [mpfsa_pkg::OFFS_W-1:0]  acc_sum;

	assign req_fire = req.valid && req.ready;
	assign cfg_fire = cfg.valid && cfg.ready;
	assign cfg_hit  = cfg_fire && (int'(cfg.addr) < mpfsa_pkg::CFG_NUM_REGS);

	assign pool_ok   = int'(req.pool_id) < NP;
	assign cur_cnt   = cnt_q[req.pool_id];
	assign cur_low   = low_q[req.pool_id];
	assign cur_lim   = mpfsa_pkg::eff_limit(limit_q[req.pool_id]);
	assign cur_bytes = mpfsa_pkg::eff_bytes(bytes_q[req.pool_id]);
	assign cnt_dec   = cur_cnt - mpfsa_pkg::CNT_W'(1);
	assign cnt_inc   = cur_cnt + mpfsa_pkg::CNT_W'(1);
	// An entry below the low-water mark was never pushed since refill: it holds its refill default
	assign use_ram   = cnt_dec >= cur_low;
	assign dflt_slot = cur_lim - mpfsa_pkg::CNT_W'(1) - cnt_dec;

	assign alloc_ok = pool_ok && (req.kind == mpfsa_pkg::KIND_ALLOC) && (cur_cnt != '0);
	assign free_ok  = pool_ok && (req.kind == mpfsa_pkg::KIND_FREE) && (cur_cnt < cur_lim)
		&& (mpfsa_pkg::CNT_W'(req.slot_in) < cur_lim);

	// Stack memory: push writes at the count, pop reads below it
	assign ram_we    = req_fire && free_ok;
	assign ram_waddr = {req.pool_id, cur_cnt[mpfsa_pkg::SLOT_W-1:0]};
	assign ram_raddr = {req.pool_id, cnt_dec[mpfsa_pkg::SLOT_W-1:0]};

	mpfsa_ram #(
		.WIDTH (mpfsa_pkg::SLOT_W),
		.DEPTH (mpfsa_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.slot_in),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Register values after a pending write, used for the refill
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			limit_d[i] = limit_q[i];
			if (cfg_fire && (int'(cfg.addr) == mpfsa_pkg::CFG_LIMIT_BASE + i))
				limit_d[i] = cfg.data[mpfsa_pkg::LIMIT_W-1:0];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) begin
				limit_q[i] <= mpfsa_pkg::LIMIT_W'(mpfsa_pkg::SLOT_CAP);
				bytes_q[i] <= mpfsa_pkg::BYTES_W'(1);
			end
		end else if (cfg_fire) begin
			for (int i = 0; i < NP; i++) begin
				limit_q[i] <= limit_d[i];
				if (int'(cfg.addr) == mpfsa_pkg::CFG_BYTES_BASE + i)
					bytes_q[i] <= cfg.data;
			end
		end
	end

	// Counts and low-water marks: refill on any write to an index below CFG_NUM_REGS, else pop or push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) begin
				cnt_q[i] <= mpfsa_pkg::CNT_W'(mpfsa_pkg::SLOT_CAP);
				low_q[i] <= mpfsa_pkg::CNT_W'(mpfsa_pkg::SLOT_CAP);
			end
		end else if (cfg_hit) begin
			for (int i = 0; i < NP; i++) begin
				cnt_q[i] <= mpfsa_pkg::eff_limit(limit_d[i]);
				low_q[i] <= mpfsa_pkg::eff_limit(limit_d[i]);
			end
		end else if (req_fire && alloc_ok) begin
			cnt_q[req.pool_id] <= cnt_dec;
			if (cnt_dec < cur_low)
				low_q[req.pool_id] <= cnt_dec;
		end else if (req_fire && free_ok) begin
			cnt_q[req.pool_id] <= cnt_inc;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpfsa_pkg::FSM_IDLE:  if (req_fire) state_d = mpfsa_pkg::FSM_FETCH;
			mpfsa_pkg::FSM_FETCH: state_d = mpfsa_pkg::FSM_MUL;
			mpfsa_pkg::FSM_MUL:
				if (step_q == mpfsa_pkg::MUL_CNT_W'(mpfsa_pkg::SLOT_W - 1))
					state_d = mpfsa_pkg::FSM_OUT;
			mpfsa_pkg::FSM_OUT:   if (rsp.ready) state_d = mpfsa_pkg::FSM_IDLE;
			default:              state_d = mpfsa_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mpfsa_pkg::FSM_IDLE;
		else
			state_q <= state_d;
	end

	// Outputs
	always_comb begin
		req.ready       = state_q == mpfsa_pkg::FSM_IDLE;
		cfg.ready       = 1'b1;
		rsp.valid       = state_q == mpfsa_pkg::FSM_OUT;
		rsp.status      = status_q;
		rsp.slot_out    = slot_q;
		rsp.byte_offset = acc_q;
		rsp.free_left   = left_q;
	end

	assign slot_res = sel_ram_q ? ram_rdata : slot_q;
	assign acc_sum  = acc_q + mcand_q;

	// Item datapath: capture decision, resolve popped slot, shift-add the byte offset
	always_ff @(posedge clk) begin
		unique case (state_q)
			mpfsa_pkg::FSM_IDLE: begin
				if (req_fire) begin
					kind_q    <= req.kind;
					sel_ram_q <= alloc_ok && use_ram;
					mcand_q   <= pool_ok ? mpfsa_pkg::OFFS_W'(cur_bytes) : '0;
					if (!pool_ok) begin
						status_q <= (req.kind == mpfsa_pkg::KIND_FREE) ?
							mpfsa_pkg::ST_BAD_FREE : mpfsa_pkg::ST_EMPTY;
						slot_q   <= (req.kind == mpfsa_pkg::KIND_FREE) ? req.slot_in : '0;
						left_q   <= '0;
					end else if (req.kind == mpfsa_pkg::KIND_ALLOC) begin
						status_q <= alloc_ok ? mpfsa_pkg::ST_OK : mpfsa_pkg::ST_EMPTY;
						slot_q   <= alloc_ok ? dflt_slot[mpfsa_pkg::SLOT_W-1:0] : '0;
						left_q   <= alloc_ok ? cnt_dec : '0;
					end else begin
						status_q <= free_ok ? mpfsa_pkg::ST_OK : mpfsa_pkg::ST_BAD_FREE;
						slot_q   <= req.slot_in;
						left_q   <= free_ok ? cnt_inc : cur_cnt;
					end
				end
			end
			mpfsa_pkg::FSM_FETCH: begin
				slot_q   <= slot_res;
				mplier_q <= slot_res;
				acc_q    <= '0;
				step_q   <= '0;
			end
			mpfsa_pkg::FSM_MUL: begin
				if (mplier_q[0])
					acc_q <= acc_sum;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				step_q   <= step_q + mpfsa_pkg::MUL_CNT_W'(1);
			end
			mpfsa_pkg::FSM_OUT: begin
				// hold the result until transfer
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_accept_to_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == mpfsa_pkg::FSM_FETCH)
		else $error("accepted request did not start the stack read");

	a_push_only_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (req_fire && req.kind == mpfsa_pkg::KIND_FREE))
		else $error("stack written without an accepted free");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == mpfsa_pkg::ST_EMPTY) |->
		(rsp.slot_out == '0 && rsp.byte_offset == '0 && rsp.free_left == '0))
		else $error("empty-pool response carries nonzero fields");

	a_bad_free_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == mpfsa_pkg::ST_BAD_FREE) |-> kind_q == mpfsa_pkg::KIND_FREE)
		else $error("bad-free status on an allocate request");

endmodule
`default_nettype wire

### bench/tb_multi_pool_free_stack_allocator.sv
// Self-checking testbench for the four-pool free-stack slot allocator.
`timescale 1ns / 1ps
module tb_multi_pool_free_stack_allocator;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 160;
	localparam int REPORT_MAX  = 10;
	localparam int NP          = mpfsa_pkg::NUM_POOLS;
	localparam int CAP         = mpfsa_pkg::SLOT_CAP;

	typedef struct {
		mpfsa_pkg::status_t           status;
		logic [mpfsa_pkg::SLOT_W-1:0] slot;
		logic [mpfsa_pkg::OFFS_W-1:0] offset;
		logic [mpfsa_pkg::CNT_W-1:0]  left;
	} alloc_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mpfsa_req_if req_ch();
	mpfsa_rsp_if rsp_ch();
	mpfsa_cfg_if cfg_ch();

	multi_pool_free_stack_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the pool registers and free stacks
	logic [mpfsa_pkg::LIMIT_W-1:0] limit_regs [NP];
	logic [mpfsa_pkg::BYTES_W-1:0] size_regs  [NP];
	logic [mpfsa_pkg::SLOT_W-1:0]  free_slots [NP][CAP];
	logic [mpfsa_pkg::CNT_W-1:0]   free_total [NP];
	// Slots handed out, used to build well-formed free requests
	logic [mpfsa_pkg::SLOT_W-1:0]  held_slots [NP][$];

	alloc_result_t expected_q [$];
	alloc_result_t want;

	int  mismatches  = 0;
	int  good_allocs = 0;
	int  empty_hits  = 0;
	int  good_frees  = 0;
	int  bad_frees   = 0;
	int  cfg_writes  = 0;
	int  hold_request = 0;
	bit  source_gaps = 1'b0;
	bit  sink_stalls = 1'b0;

	always #10 clk = ~clk;

	function automatic int usable_limit(int p);
		int v;
		v = limit_regs[p];
		if (v < 1) v = 1;
		if (v > CAP) v = CAP;
		return v;
	endfunction

	function automatic int usable_size(int p);
		int v;
		v = size_regs[p];
		if (v < 1) v = 1;
		if (v > mpfsa_pkg::BYTES_MAX) v = mpfsa_pkg::BYTES_MAX;
		return v;
	endfunction

	// Refill every stack so that allocations hand out 0, 1, 2 and onward
	function automatic void restock_pools();
		int lim;
		for (int p = 0; p < NP; p++) begin
			lim = usable_limit(p);
			for (int i = 0; i < CAP; i++)
				free_slots[p][i] = (i < lim) ? mpfsa_pkg::SLOT_W'(lim - 1 - i) : '0;
			free_total[p] = mpfsa_pkg::CNT_W'(lim);
			held_slots[p].delete();
		end
	endfunction

	// Apply one request to the shadow pools and return the result it yields
	function automatic alloc_result_t serve_request(mpfsa_pkg::kind_t k, int p,
			logic [mpfsa_pkg::SLOT_W-1:0] s);
		alloc_result_t r;
		int cnt;
		int lim;
		cnt = free_total[p];
		lim = usable_limit(p);
		r.status = mpfsa_pkg::ST_OK;
		r.slot   = '0;
		r.offset = '0;
		r.left   = '0;
		if (k == mpfsa_pkg::KIND_ALLOC) begin
			if (cnt == 0 || cnt > CAP) begin
				r.status = mpfsa_pkg::ST_EMPTY;
				empty_hits++;
			end else begin
				cnt--;
				r.slot        = free_slots[p][cnt];
				free_total[p] = mpfsa_pkg::CNT_W'(cnt);
				r.offset      = mpfsa_pkg::OFFS_W'(int'(r.slot) * usable_size(p));
				r.left        = mpfsa_pkg::CNT_W'(cnt);
				held_slots[p].push_back(r.slot);
				good_allocs++;
			end
		end else begin
			r.slot   = s;
			r.offset = mpfsa_pkg::OFFS_W'(int'(s) * usable_size(p));
			if (cnt >= lim || int'(s) >= lim) begin
				r.status = mpfsa_pkg::ST_BAD_FREE;
				r.left   = mpfsa_pkg::CNT_W'(cnt);
				bad_frees++;
			end else begin
				free_slots[p][cnt] = s;
				cnt++;
				free_total[p] = mpfsa_pkg::CNT_W'(cnt);
				r.left        = mpfsa_pkg::CNT_W'(cnt);
				good_frees++;
			end
		end
		return r;
	endfunction

	// Offer one request, hold it until the transfer, then record its result
	task automatic send_request(mpfsa_pkg::kind_t k, logic [mpfsa_pkg::POOL_W-1:0] p,
			logic [mpfsa_pkg::SLOT_W-1:0] s);
		if (source_gaps && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.kind    <= k;
		req_ch.pool_id <= p;
		req_ch.slot_in <= s;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_q.push_back(serve_request(k, p, s));
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Write one register; the block refills its stacks on a known index
	task automatic write_register(int idx, logic [mpfsa_pkg::CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= mpfsa_pkg::CFG_ADDR_W'(idx);
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
		if (idx >= mpfsa_pkg::CFG_LIMIT_BASE && idx < mpfsa_pkg::CFG_LIMIT_BASE + NP) begin
			limit_regs[idx - mpfsa_pkg::CFG_LIMIT_BASE] = value[mpfsa_pkg::LIMIT_W-1:0];
			restock_pools();
		end else if (idx >= mpfsa_pkg::CFG_BYTES_BASE &&
				idx < mpfsa_pkg::CFG_BYTES_BASE + NP) begin
			size_regs[idx - mpfsa_pkg::CFG_BYTES_BASE] = value[mpfsa_pkg::BYTES_W-1:0];
			restock_pools();
		end
		@(posedge clk);
	endtask

	// Pick a new random setting for every pool, extremes included
	task automatic program_pools();
		int pick;
		logic [mpfsa_pkg::CFG_DATA_W-1:0] value;
		for (int p = 0; p < NP; p++) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5)      value = mpfsa_pkg::CFG_DATA_W'($urandom_range(1, 8));
			else if (pick == 6) value = '0;
			else if (pick == 7) value = mpfsa_pkg::CFG_DATA_W'(CAP);
			else if (pick == 8) value = mpfsa_pkg::CFG_DATA_W'($urandom_range(CAP + 1, 8191));
			else                value = mpfsa_pkg::CFG_DATA_W'($urandom_range(9, CAP - 1));
			write_register(mpfsa_pkg::CFG_LIMIT_BASE + p, value);
		end
		for (int p = 0; p < NP; p++) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3)
				value = mpfsa_pkg::CFG_DATA_W'($urandom_range(1, mpfsa_pkg::BYTES_MAX));
			else if (pick == 4)
				value = '0;
			else if (pick == 5)
				value = mpfsa_pkg::CFG_DATA_W'(mpfsa_pkg::BYTES_MAX);
			else if (pick == 6)
				value = mpfsa_pkg::CFG_DATA_W'($urandom_range(mpfsa_pkg::BYTES_MAX + 1, 8191));
			else
				value = mpfsa_pkg::CFG_DATA_W'($urandom);
			write_register(mpfsa_pkg::CFG_BYTES_BASE + p, value);
		end
		// Index past the register list: must leave the pools alone
		if ($urandom_range(0, 2) == 0)
			write_register($urandom_range(mpfsa_pkg::CFG_NUM_REGS, 15),
				mpfsa_pkg::CFG_DATA_W'($urandom));
	endtask

	// Out of reset pools 0 and 3 hand out slots in ascending order
	task automatic test_reset_order();
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd0, 8'd0);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd0, 8'hFF);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd0, 8'd0);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd3, 8'd0);
		drain_results();
	endtask

	// Clamped settings, empty pool, full stack, out-of-range and double frees
	task automatic test_special_cases();
		write_register(mpfsa_pkg::CFG_LIMIT_BASE + 0, 13'h1FFF);
		write_register(mpfsa_pkg::CFG_BYTES_BASE + 0, 13'h0000);
		write_register(mpfsa_pkg::CFG_LIMIT_BASE + 1, 13'd1);
		write_register(mpfsa_pkg::CFG_BYTES_BASE + 1, 13'd4096);
		write_register(mpfsa_pkg::CFG_LIMIT_BASE + 2, 13'h0200);
		write_register(mpfsa_pkg::CFG_BYTES_BASE + 2, 13'h1FFF);
		write_register(mpfsa_pkg::CFG_LIMIT_BASE + 3, 13'd256);
		write_register(mpfsa_pkg::CFG_BYTES_BASE + 3, 13'd4095);
		write_register(mpfsa_pkg::CFG_NUM_REGS + 7, 13'h1FFF);
		// single-slot pool: full, then empty, then out of range
		send_request(mpfsa_pkg::KIND_FREE,  2'd1, 8'd0);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd1, 8'd0);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd1, 8'd0);
		send_request(mpfsa_pkg::KIND_FREE,  2'd1, 8'hFF);
		send_request(mpfsa_pkg::KIND_FREE,  2'd1, 8'd0);
		// limit clamped up from zero
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd2, 8'd0);
		send_request(mpfsa_pkg::KIND_FREE,  2'd2, 8'd0);
		send_request(mpfsa_pkg::KIND_FREE,  2'd2, 8'd0);
		// double free accepted until the stack is full
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd3, 8'd0);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd3, 8'd0);
		send_request(mpfsa_pkg::KIND_FREE,  2'd3, 8'hFF);
		send_request(mpfsa_pkg::KIND_FREE,  2'd3, 8'd0);
		send_request(mpfsa_pkg::KIND_FREE,  2'd3, 8'd1);
		// freed slot comes out on top of the stack
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd0, 8'd0);
		send_request(mpfsa_pkg::KIND_FREE,  2'd0, 8'hFF);
		send_request(mpfsa_pkg::KIND_ALLOC, 2'd0, 8'd0);
		drain_results();
	endtask

	// Mostly allocate/free pairs on random pools, some stray frees
	task automatic test_random_traffic(int items);
		int p;
		int pick;
		int idx;
		int lim;
		logic [mpfsa_pkg::SLOT_W-1:0] s;
		for (int n = 0; n < items; n++) begin
			p    = $urandom_range(0, NP - 1);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_request(mpfsa_pkg::KIND_ALLOC, mpfsa_pkg::POOL_W'(p),
					mpfsa_pkg::SLOT_W'($urandom));
			end else if (pick < 85 && held_slots[p].size() != 0) begin
				idx = $urandom_range(0, held_slots[p].size() - 1);
				s   = held_slots[p][idx];
				held_slots[p].delete(idx);
				send_request(mpfsa_pkg::KIND_FREE, mpfsa_pkg::POOL_W'(p), s);
			end else begin
				lim = usable_limit(p);
				if ($urandom_range(0, 1) == 0) s = mpfsa_pkg::SLOT_W'($urandom);
				else                           s = mpfsa_pkg::SLOT_W'($urandom_range(0, lim));
				send_request(mpfsa_pkg::KIND_FREE, mpfsa_pkg::POOL_W'(p), s);
			end
		end
		drain_results();
	endtask

	// Stall the result side long enough that the request side backs up
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		for (int n = 0; n < 30; n++)
			send_request(n % 3 == 2 ? mpfsa_pkg::KIND_FREE : mpfsa_pkg::KIND_ALLOC,
				mpfsa_pkg::POOL_W'(n % NP), mpfsa_pkg::SLOT_W'(n));
		drain_results();
		// pause the sender until everything is back, then resume
		for (int n = 0; n < 20; n++)
			send_request(mpfsa_pkg::KIND_ALLOC, mpfsa_pkg::POOL_W'($urandom), '0);
		drain_results();
	endtask

	// Result side ready: random stall bursts plus one long requested hold
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				rsp_ch.ready <= 1'b1;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each transferred result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with none expected: status %0d slot %0d off %0d left %0d",
						$realtime, rsp_ch.status, rsp_ch.slot_out, rsp_ch.byte_offset,
						rsp_ch.free_left);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.slot_out !== want.slot ||
						rsp_ch.byte_offset !== want.offset || rsp_ch.free_left !== want.left) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: expected status %0d slot %0d off %0d left %0d, got %0d %0d %0d %0d",
							$realtime, want.status, want.slot, want.offset, want.left,
							rsp_ch.status, rsp_ch.slot_out, rsp_ch.byte_offset, rsp_ch.free_left);
				end
			end
		end
	end

	// Abort when no channel has moved a transfer for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d cycles without a transfer", quiet);
		$display("simulation failed");
		$finish;
	end

	initial begin
		req_ch.valid   = 1'b0;
		req_ch.kind    = 1'b0;
		req_ch.pool_id = '0;
		req_ch.slot_in = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.addr    = '0;
		cfg_ch.data    = '0;
		for (int p = 0; p < NP; p++) begin
			limit_regs[p] = mpfsa_pkg::LIMIT_W'(CAP);
			size_regs[p]  = mpfsa_pkg::BYTES_W'(1);
		end
		restock_pools();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_order();
		test_special_cases();
		test_backpressure();
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			program_pools();
			test_random_traffic(100);
		end
		// closing stretch at full rate
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		program_pools();
		test_random_traffic(80);
		repeat (20) @(posedge clk);

		mismatches += expected_q.size();
		$display("covered %0d allocations, %0d empty pools, %0d frees, %0d rejected frees",
			good_allocs, empty_hits, good_frees, bad_frees);
		$display("with %0d register writes, long result stall and drain pauses; %0d mismatches",
			cfg_writes, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
